// ----- hdl/clpw_pkg.sv -----
// ----------------------------------------------------------------------------
// Character LCD parallel writer package
// Shared types, codes and constants of the character LCD writer.
// ----------------------------------------------------------------------------
`default_nettype none

package clpw_pkg;

  localparam int OPCODE_W = 2;
  localparam int COLUMN_W = 6;
  localparam int ADDR_W   = 7;
  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 3;

  // Input operations
  localparam logic [OPCODE_W-1:0] OP_INIT       = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CLEAR      = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_WRITE_AT   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_WRITE_NEXT = 2'd3;

  // Job kinds held in the queue
  localparam logic [1:0] KIND_INIT  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_SET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_CTRL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_PULSE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_GAP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_WAIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BASE     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 3'd7;

  // LCD commands
  localparam logic [BYTE_W-1:0] CMD_CLEAR    = 8'h01;
  localparam logic              CMD_SET_ADDR = 1'b1;

  // Reset values of the registers
  localparam logic [BYTE_W-1:0]   RST_FUNCTION_SET = 8'h38;
  localparam logic [BYTE_W-1:0]   RST_DISPLAY_CTRL = 8'h0c;
  localparam logic [BYTE_W-1:0]   RST_ENABLE_PULSE = 8'd40;
  localparam logic [BYTE_W-1:0]   RST_INIT_GAP     = 8'd5;
  localparam logic [BYTE_W-1:0]   RST_CLEAR_WAIT   = 8'd20;
  localparam logic [BYTE_W-1:0]   RST_POWER_UP     = 8'd40;
  localparam logic [ADDR_W-1:0]   RST_ROW_BASE     = 7'h40;
  localparam logic [COLUMN_W-1:0] RST_COLUMN_COUNT = 6'd16;

  // Step numbers of the init sequence
  localparam logic [2:0] STEP_DISPLAY_CTRL = 3'd3;
  localparam logic [2:0] STEP_INIT_LAST    = 3'd4;

  // First dividend bit of the column remainder, taken one bit per cycle
  localparam logic [2:0] MOD_FIRST_BIT = 3'd6;

  typedef struct packed {
    logic [BYTE_W-1:0]   function_set_cmd;
    logic [BYTE_W-1:0]   display_ctrl_cmd;
    logic [BYTE_W-1:0]   enable_pulse_us;
    logic [BYTE_W-1:0]   init_gap_ms;
    logic [BYTE_W-1:0]   clear_wait_ms;
    logic [BYTE_W-1:0]   power_up_wait_ms;
    logic [ADDR_W-1:0]   second_row_base;
    logic [COLUMN_W-1:0] column_count;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] character;
  } job_t;

  typedef struct packed {
    logic register_select;
    logic [BYTE_W-1:0] bus_byte;
    logic [BYTE_W-1:0] wait_before_ms;
    logic [BYTE_W-1:0] wait_after_ms;
    logic last;
  } xfer_t;

endpackage

`default_nettype wire

// ----- hdl/clpw_front.sv -----
// ----------------------------------------------------------------------------
// Character LCD writer front end
// Accepts requests, tracks the cursor and turns each request into a job.
// ----------------------------------------------------------------------------
`default_nettype none

module clpw_front
  import clpw_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cfg_t                cfg,
  input  wire logic                in_valid,
  input  wire logic [OPCODE_W-1:0] opcode,
  input  wire logic                row,
  input  wire logic [COLUMN_W-1:0] column,
  input  wire logic [BYTE_W-1:0]   character,
  input  wire logic                queue_full,
  output logic                     in_ready,
  output logic                     push,
  output job_t                     job
);

  logic                current_row;
  logic [COLUMN_W-1:0] current_column;
  logic                row_sel;
  logic [COLUMN_W-1:0] col_sel;
  logic [ADDR_W-1:0]   base;
  logic [ADDR_W-1:0]   addr;
  logic                is_write;
  logic                start_at;
  logic                count_changed;
  logic [COLUMN_W-1:0] count_seen;
  logic [ADDR_W-1:0]   divisor;
  logic                adv_busy;
  logic [2:0]          adv_bit;
  logic [ADDR_W-1:0]   adv_dividend;
  logic [ADDR_W-1:0]   adv_rem;
  logic [ADDR_W-1:0]   rem_shift;
  logic [ADDR_W-1:0]   rem_step;
  logic [COLUMN_W-1:0] adv_col;
  logic [ADDR_W-1:0]   adv_inc;
  logic [COLUMN_W-1:0] adv_wrap;
  logic [COLUMN_W-1:0] restart_col;

  // The column after the cursor is kept ready in adv_col. After a write-at, a
  // change of column count or reset it is rebuilt as a remainder, one dividend
  // bit per cycle; a write-next only steps it on, since it is already below
  // the column count. A zero column count acts as 64.
  assign count_changed = (count_seen != cfg.column_count);
  assign in_ready      = !queue_full && !adv_busy && !count_changed;
  assign push          = in_valid && in_ready;
  assign is_write      = (opcode == OP_WRITE_AT) || (opcode == OP_WRITE_NEXT);
  assign start_at      = push && (opcode == OP_WRITE_AT);
  assign divisor       = (cfg.column_count == '0) ? 7'd64 : {1'b0, cfg.column_count};
  assign rem_shift     = {adv_rem[COLUMN_W-1:0], adv_dividend[ADDR_W-1]};
  assign rem_step      = (rem_shift >= divisor) ? rem_shift - divisor : rem_shift;
  assign adv_inc       = {1'b0, adv_col} + 7'd1;
  assign adv_wrap      = (adv_inc == divisor) ? '0 : adv_inc[COLUMN_W-1:0];
  assign restart_col   = start_at ? column : current_column;

  always_comb begin
    row_sel = (opcode == OP_WRITE_AT) ? row : current_row;
    col_sel = (opcode == OP_WRITE_AT) ? column : adv_col;
    base    = row_sel ? cfg.second_row_base : '0;
    addr    = base + {1'b0, col_sel};
    job.cmd = {CMD_SET_ADDR, addr};
    job.character = character;
    case (opcode)
      OP_INIT:  job.kind = KIND_INIT;
      OP_CLEAR: job.kind = KIND_CLEAR;
      default:  job.kind = KIND_WRITE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_row    <= 1'b0;
      current_column <= '0;
    end else if (push && is_write) begin
      current_row    <= row_sel;
      current_column <= col_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_seen   <= RST_COLUMN_COUNT;
      adv_busy     <= 1'b1;
      adv_bit      <= MOD_FIRST_BIT;
      adv_dividend <= 7'd1;
      adv_rem      <= '0;
      adv_col      <= '0;
    end else if (start_at || count_changed) begin
      count_seen   <= cfg.column_count;
      adv_busy     <= 1'b1;
      adv_bit      <= MOD_FIRST_BIT;
      adv_dividend <= {1'b0, restart_col} + 7'd1;
      adv_rem      <= '0;
    end else if (adv_busy) begin
      adv_dividend <= {adv_dividend[ADDR_W-2:0], 1'b0};
      adv_rem      <= rem_step;
      if (adv_bit == '0) begin
        adv_busy <= 1'b0;
        adv_col  <= rem_step[COLUMN_W-1:0];
      end else begin
        adv_bit <= adv_bit - 3'd1;
      end
    end else if (push && (opcode == OP_WRITE_NEXT)) begin
      adv_col <= adv_wrap;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/clpw_queue.sv -----
// ----------------------------------------------------------------------------
// Character LCD writer job queue
// Two-entry first-word-fall-through queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module clpw_queue
  import clpw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output job_t      head
);

  job_t       entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (do_pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into a full queue");

endmodule

`default_nettype wire

// ----- hdl/clpw_back.sv -----
// ----------------------------------------------------------------------------
// Character LCD writer back end
// Expands each job into bus transfers held in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module clpw_back
  import clpw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic head_valid,
  input  wire job_t head,
  output logic      pop,
  input  wire logic out_ready,
  output logic      out_valid,
  output xfer_t     out_xfer
);

  logic [2:0] step;
  logic [2:0] step_next;
  xfer_t      gen;
  logic       load;

  always_comb begin
    gen.register_select = 1'b0;
    gen.bus_byte        = cfg.function_set_cmd;
    gen.wait_before_ms  = '0;
    gen.wait_after_ms   = '0;
    gen.last            = 1'b0;
    case (head.kind)
      KIND_INIT: begin
        if (step == '0) begin
          gen.wait_before_ms = cfg.power_up_wait_ms;
        end
        if (step == STEP_DISPLAY_CTRL) begin
          gen.bus_byte = cfg.display_ctrl_cmd;
        end
        if (step == STEP_INIT_LAST) begin
          gen.bus_byte      = CMD_CLEAR;
          gen.wait_after_ms = cfg.clear_wait_ms;
          gen.last          = 1'b1;
        end else begin
          gen.wait_after_ms = cfg.init_gap_ms;
        end
      end
      KIND_CLEAR: begin
        gen.bus_byte      = CMD_CLEAR;
        gen.wait_after_ms = cfg.clear_wait_ms;
        gen.last          = 1'b1;
      end
      default: begin
        if (step == '0) begin
          gen.bus_byte = head.cmd;
        end else begin
          gen.register_select = 1'b1;
          gen.bus_byte        = head.character;
          gen.last            = 1'b1;
        end
      end
    endcase
  end

  assign load      = !out_valid || out_ready;
  assign pop       = load && head_valid && gen.last;
  assign step_next = gen.last ? 3'd0 : step + 3'd1;

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_xfer <= gen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        step <= step_next;
      end
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst) step <= STEP_INIT_LAST)
    else $error("transfer step out of range");
  a_step_needs_job: assert property (@(posedge clk) disable iff (rst)
    (step != '0) |-> head_valid)
    else $error("job in progress without a queued job");
  a_write_two_steps: assert property (@(posedge clk) disable iff (rst)
    (head_valid && head.kind == KIND_WRITE) |-> (step <= 3'd1))
    else $error("write job past its data transfer");

endmodule

`default_nettype wire

// ----- hdl/char_lcd_parallel_writer_top.sv -----
// ----------------------------------------------------------------------------
// Character LCD parallel writer
// Turns LCD requests (init, clear, write-at, write-next) into a stream of
// 8-bit bus transfers, each with register select, byte and wait times.
//
// Requests arrive on the s_ group, transfers leave on the m_ group with
// tlast on the final transfer of each request. Registers are written
// through cfg_we, cfg_index and cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce.
// The front end takes a request and places a job in a two-entry queue;
// the job passes through the queue and the back end's output register
// before m_tvalid rises for its first transfer.
// The back end emits one transfer per cycle through its output register
// while the receiver is ready, so a request gives one (clear), two
// (writes) or five (init) transfers. The front end rebuilds the column
// after the cursor bit by bit with s_tready low after a write-at, a reset
// or a change of column count; a write-next steps it on at once.
// A stalled receiver holds the output register; requests are still taken
// until the queue fills. Reset loads the register defaults, clears the
// cursor to row 0, column 0 and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_parallel_writer_top
  import clpw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [15:0]          s_tdata,  // row, column, character, zero pad
  input  wire logic [OPCODE_W-1:0]  s_tuser,  // opcode
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [31:0]               m_tdata,  // register_select, bus_byte,
                                              // wait_before_ms, wait_after_ms, zero pad
  output logic                      m_tlast,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data
);

  cfg_t  cfg;
  job_t  front_job;
  job_t  head;
  xfer_t xfer;
  logic  push;
  logic  pop;
  logic  full;
  logic  head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.function_set_cmd <= RST_FUNCTION_SET;
      cfg.display_ctrl_cmd <= RST_DISPLAY_CTRL;
      cfg.enable_pulse_us  <= RST_ENABLE_PULSE;
      cfg.init_gap_ms      <= RST_INIT_GAP;
      cfg.clear_wait_ms    <= RST_CLEAR_WAIT;
      cfg.power_up_wait_ms <= RST_POWER_UP;
      cfg.second_row_base  <= RST_ROW_BASE;
      cfg.column_count     <= RST_COLUMN_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FUNCTION_SET: cfg.function_set_cmd <= cfg_data;
        CFG_DISPLAY_CTRL: cfg.display_ctrl_cmd <= cfg_data;
        CFG_ENABLE_PULSE: cfg.enable_pulse_us  <= cfg_data;
        CFG_INIT_GAP:     cfg.init_gap_ms      <= cfg_data;
        CFG_CLEAR_WAIT:   cfg.clear_wait_ms    <= cfg_data;
        CFG_POWER_UP:     cfg.power_up_wait_ms <= cfg_data;
        CFG_ROW_BASE:     cfg.second_row_base  <= cfg_data[ADDR_W-1:0];
        CFG_COLUMN_COUNT: cfg.column_count     <= cfg_data[COLUMN_W-1:0];
        default: ;
      endcase
    end
  end

  clpw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .opcode     (s_tuser),
    .row        (s_tdata[0]),
    .column     (s_tdata[6:1]),
    .character  (s_tdata[14:7]),
    .queue_full (full),
    .in_ready   (s_tready),
    .push       (push),
    .job        (front_job)
  );

  clpw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (front_job),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  clpw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_xfer   (xfer)
  );

  assign m_tdata = {7'd0, xfer.wait_after_ms, xfer.wait_before_ms, xfer.bus_byte,
                    xfer.register_select};
  assign m_tlast = xfer.last;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD parallel writer testbench
// Sends init, clear, write-at and write-next requests under several register
// settings, predicts every bus transfer from its own model of the registers
// and the cursor, and compares each transfer field by field as it leaves.
// ----------------------------------------------------------------------------
module tb;
  import clpw_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PERCENT = 27;
  localparam int DRAIN_CYCLES = 8;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata = '0;  // row, column, character, zero pad
  logic [OPCODE_W-1:0]  s_tuser = OP_INIT;  // opcode
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;  // register_select, bus_byte, wait_before_ms,
                                  // wait_after_ms, zero pad
  logic                 m_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FUNCTION_SET;
  logic [BYTE_W-1:0]    cfg_data = '0;

  cfg_t                 lcd_cfg;
  logic                 cursor_row;
  logic [COLUMN_W-1:0]  cursor_column;
  xfer_t                pending_transfers[$];
  bit                   steady_flow = 1'b0;
  int                   mismatches = 0;
  int                   cycle_count = 0;

  char_lcd_parallel_writer_top dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("char_lcd_parallel_writer_top verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
  end

  function automatic void predict_request(input logic [OPCODE_W-1:0] op, input logic row,
                                          input logic [COLUMN_W-1:0] column,
                                          input logic [BYTE_W-1:0] character);
    logic [ADDR_W-1:0]   address;
    logic [6:0]          modulus;
    logic                target_row;
    logic [COLUMN_W-1:0] target_column;
    case (op)
      OP_INIT: begin
        pending_transfers.push_back('{1'b0, lcd_cfg.function_set_cmd,
                                      lcd_cfg.power_up_wait_ms, lcd_cfg.init_gap_ms, 1'b0});
        pending_transfers.push_back('{1'b0, lcd_cfg.function_set_cmd, 8'd0,
                                      lcd_cfg.init_gap_ms, 1'b0});
        pending_transfers.push_back('{1'b0, lcd_cfg.function_set_cmd, 8'd0,
                                      lcd_cfg.init_gap_ms, 1'b0});
        pending_transfers.push_back('{1'b0, lcd_cfg.display_ctrl_cmd, 8'd0,
                                      lcd_cfg.init_gap_ms, 1'b0});
        pending_transfers.push_back('{1'b0, CMD_CLEAR, 8'd0, lcd_cfg.clear_wait_ms, 1'b1});
      end
      OP_CLEAR: begin
        pending_transfers.push_back('{1'b0, CMD_CLEAR, 8'd0, lcd_cfg.clear_wait_ms, 1'b1});
      end
      default: begin
        if (op == OP_WRITE_AT) begin
          target_row    = row;
          target_column = column;
        end else begin
          // A column count of zero wraps the advance at the full six bits.
          modulus       = (lcd_cfg.column_count == '0) ? 7'd64 : {1'b0, lcd_cfg.column_count};
          target_column = COLUMN_W'((cursor_column + 7'd1) % modulus);
          target_row    = cursor_row;
        end
        address = (target_row ? lcd_cfg.second_row_base : '0) + ADDR_W'(target_column);
        pending_transfers.push_back('{1'b0, {CMD_SET_ADDR, address}, 8'd0, 8'd0, 1'b0});
        pending_transfers.push_back('{1'b1, character, 8'd0, 8'd0, 1'b1});
        cursor_row    = target_row;
        cursor_column = target_column;
      end
    endcase
  endfunction

  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic row,
                              input logic [COLUMN_W-1:0] column,
                              input logic [BYTE_W-1:0] character);
    if (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, character, column, row};
    do @(posedge clk); while (!s_tready);
    predict_request(op, row, column, character);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_transfers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input cfg_t next_cfg);
    logic [BYTE_W-1:0] values [8];
    values[CFG_FUNCTION_SET] = next_cfg.function_set_cmd;
    values[CFG_DISPLAY_CTRL] = next_cfg.display_ctrl_cmd;
    values[CFG_ENABLE_PULSE] = next_cfg.enable_pulse_us;
    values[CFG_INIT_GAP]     = next_cfg.init_gap_ms;
    values[CFG_CLEAR_WAIT]   = next_cfg.clear_wait_ms;
    values[CFG_POWER_UP]     = next_cfg.power_up_wait_ms;
    values[CFG_ROW_BASE]     = {1'b0, next_cfg.second_row_base};
    values[CFG_COLUMN_COUNT] = {2'b00, next_cfg.column_count};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= values[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    lcd_cfg = next_cfg;
  endtask

  function automatic cfg_t random_config();
    cfg_t picked;
    picked.function_set_cmd = BYTE_W'($urandom);
    picked.display_ctrl_cmd = BYTE_W'($urandom);
    picked.enable_pulse_us  = BYTE_W'($urandom_range(255, 1));
    picked.init_gap_ms      = BYTE_W'($urandom);
    picked.clear_wait_ms    = BYTE_W'($urandom);
    picked.power_up_wait_ms = BYTE_W'($urandom);
    picked.second_row_base  = ADDR_W'($urandom);
    picked.column_count     = ($urandom_range(9) == 0) ? '0 : COLUMN_W'($urandom_range(40, 1));
    return picked;
  endfunction

  always @(posedge clk) begin : check_transfers
    xfer_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_transfers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected transfer: rs=%0d byte=%02h before=%0d after=%0d last=%0d",
                   m_tdata[0], m_tdata[8:1], m_tdata[16:9], m_tdata[24:17], m_tlast);
      end else begin
        want = pending_transfers.pop_front();
        if (m_tdata[0] !== want.register_select || m_tdata[8:1] !== want.bus_byte ||
            m_tdata[16:9] !== want.wait_before_ms || m_tdata[24:17] !== want.wait_after_ms ||
            m_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Transfer mismatch: expected rs=%0d byte=%02h before=%0d after=%0d ",
                      "last=%0d, got rs=%0d byte=%02h before=%0d after=%0d last=%0d"},
                     want.register_select, want.bus_byte, want.wait_before_ms,
                     want.wait_after_ms, want.last, m_tdata[0], m_tdata[8:1],
                     m_tdata[16:9], m_tdata[24:17], m_tlast);
        end
      end
    end
  end

  task automatic test_reset_defaults();
    send_request(OP_INIT, 1'b0, 6'd0, 8'h00);
    send_request(OP_CLEAR, 1'b1, 6'd39, 8'hff);
    send_request(OP_WRITE_AT, 1'b0, 6'd0, 8'h41);
    send_request(OP_WRITE_NEXT, 1'b1, 6'd0, 8'h42);
    send_request(OP_WRITE_AT, 1'b1, 6'd39, 8'hff);
    send_request(OP_WRITE_NEXT, 1'b0, 6'd5, 8'h00);
  endtask

  task automatic test_low_settings();
    settle();
    configure('{function_set_cmd: 8'h00, display_ctrl_cmd: 8'h00, enable_pulse_us: 8'd1,
                init_gap_ms: 8'd0, clear_wait_ms: 8'd0, power_up_wait_ms: 8'd0,
                second_row_base: 7'd0, column_count: 6'd1});
    send_request(OP_INIT, 1'b1, 6'd39, 8'hff);
    send_request(OP_WRITE_AT, 1'b1, 6'd0, 8'h00);
    send_request(OP_WRITE_NEXT, 1'b0, 6'd0, 8'h55);
    send_request(OP_WRITE_NEXT, 1'b0, 6'd0, 8'haa);
    send_request(OP_CLEAR, 1'b0, 6'd0, 8'h00);
  endtask

  task automatic test_high_settings();
    settle();
    configure('{function_set_cmd: 8'hff, display_ctrl_cmd: 8'hff, enable_pulse_us: 8'd255,
                init_gap_ms: 8'd255, clear_wait_ms: 8'd255, power_up_wait_ms: 8'd255,
                second_row_base: 7'd127, column_count: 6'd40});
    send_request(OP_INIT, 1'b0, 6'd0, 8'h00);
    // The second row base plus the column runs past the address range and wraps.
    send_request(OP_WRITE_AT, 1'b1, 6'd39, 8'hff);
    send_request(OP_WRITE_NEXT, 1'b0, 6'd0, 8'h80);
    send_request(OP_WRITE_AT, 1'b0, 6'd39, 8'h7f);
    send_request(OP_CLEAR, 1'b0, 6'd0, 8'h00);
  endtask

  task automatic test_column_wrap();
    settle();
    configure('{function_set_cmd: RST_FUNCTION_SET, display_ctrl_cmd: RST_DISPLAY_CTRL,
                enable_pulse_us: RST_ENABLE_PULSE, init_gap_ms: RST_INIT_GAP,
                clear_wait_ms: RST_CLEAR_WAIT, power_up_wait_ms: RST_POWER_UP,
                second_row_base: RST_ROW_BASE, column_count: 6'd0});
    send_request(OP_WRITE_AT, 1'b1, 6'd39, 8'h31);
    send_request(OP_WRITE_NEXT, 1'b0, 6'd0, 8'h32);
    send_request(OP_CLEAR, 1'b0, 6'd0, 8'h00);
    // The cursor survives a clear, so this continues from column 40 to column 41.
    send_request(OP_WRITE_NEXT, 1'b0, 6'd0, 8'h33);
  endtask

  task automatic test_random_traffic();
    logic [OPCODE_W-1:0] op;
    int                  pick;
    for (int phase = 0; phase < 5; phase++) begin
      settle();
      configure(random_config());
      steady_flow = (phase == 2);
      for (int n = 0; n < 26; n++) begin
        pick = $urandom_range(99);
        op = (pick < 10) ? OP_INIT : (pick < 20) ? OP_CLEAR :
             (pick < 60) ? OP_WRITE_AT : OP_WRITE_NEXT;
        send_request(op, 1'($urandom_range(1)), COLUMN_W'($urandom_range(39)),
                     BYTE_W'($urandom));
      end
    end
    steady_flow = 1'b0;
    settle();
  endtask

  initial begin
    lcd_cfg = '{function_set_cmd: RST_FUNCTION_SET, display_ctrl_cmd: RST_DISPLAY_CTRL,
                enable_pulse_us: RST_ENABLE_PULSE, init_gap_ms: RST_INIT_GAP,
                clear_wait_ms: RST_CLEAR_WAIT, power_up_wait_ms: RST_POWER_UP,
                second_row_base: RST_ROW_BASE, column_count: RST_COLUMN_COUNT};
    cursor_row    = 1'b0;
    cursor_column = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_low_settings();
    test_high_settings();
    test_column_wrap();
    test_random_traffic();
    if (mismatches == 0) begin
      $display("char_lcd_parallel_writer_top verification clean");
    end else begin
      $display("char_lcd_parallel_writer_top verification failed");
    end
    $finish;
  end

endmodule
